>>> hdl/gate_array_pixel_decode_defines.svh
// assertion macros shared by the decoder modules
// they expect clk and arst_n in the scope of use
`ifndef GATE_ARRAY_PIXEL_DECODE_DEFINES_SVH
`define GATE_ARRAY_PIXEL_DECODE_DEFINES_SVH

// consequent checked in the same cycle
`define GAPD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gapd assertion failed");

// consequent checked in the cycle after the antecedent
`define GAPD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gapd assertion failed");

`endif

>>> hdl/gapd_pkg.sv
`timescale 1ns / 1ps

package gapd_pkg;

	typedef enum logic [1:0] {
		MODE_LOW,
		MODE_MEDIUM,
		MODE_HIGH,
		MODE_NONE
	} screen_mode_t;

	localparam logic [1:0] REG_SCREEN_MODE  = 2'd0;
	localparam logic [1:0] REG_PALETTE_LOW  = 2'd1;
	localparam logic [1:0] REG_PALETTE_HIGH = 2'd2;

	localparam int PAL_W    = 40;
	localparam int COLOUR_W = 5;
	localparam int PEN_W    = 4;

	typedef struct packed {
		logic [7:0] second_byte;
		logic [7:0] first_byte;
	} pair_t;

	typedef struct packed {
		screen_mode_t       mode;
		logic [PAL_W-1:0]   pal_high;
		logic [PAL_W-1:0]   pal_low;
	} cfg_t;

	// head of the queue as seen by the back end
	typedef struct packed {
		logic  valid;
		pair_t pair;
	} queue_head_t;

	// pen of the pixel at position pos (0 leftmost) of one byte
	function automatic logic [PEN_W-1:0] pen_of(screen_mode_t mode, logic [7:0] b,
			logic [2:0] pos);
		logic [7:0]       d0;
		logic [7:0]       d1;
		logic [PEN_W-1:0] pen;
		d0 = pos[2] ? {b[6:0], 1'b0} : b;
		d1 = b << pos[2:1];
		case (mode)
			MODE_LOW:    pen = {d0[1], d0[5], d0[3], d0[7]};
			MODE_MEDIUM: pen = {2'b00, d1[3], d1[7]};
			default:     pen = {3'b000, b[3'd7 - pos]};
		endcase
		return pen;
	endfunction

	function automatic logic [COLOUR_W-1:0] colour_of(logic [PEN_W-1:0] pen,
			logic [PAL_W-1:0] pal_low, logic [PAL_W-1:0] pal_high);
		logic [PAL_W-1:0] bank;
		logic [5:0]       base;
		bank = pen[3] ? pal_high : pal_low;
		base = 6'(pen[2:0]) * 6'd5;
		return bank[base +: COLOUR_W];
	endfunction

endpackage

>>> hdl/gapd_front.sv
`timescale 1ns / 1ps
`include "gate_array_pixel_decode_defines.svh"

module gapd_front import gapd_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  screen_mode_t mode,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  pair_t       s_pair,
	output queue_head_t head,
	input  logic        pop
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	pair_t          mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           accept;
	logic           push;

	assign s_tready = (count_q != CW'(DEPTH));
	assign accept   = s_tvalid && s_tready;
	// pairs in mode none produce no pixels and are dropped here
	assign push     = accept && (mode != MODE_NONE);

	assign head.valid = (count_q != '0);
	assign head.pair  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= s_pair;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`GAPD_ASSERT_NOW(a_push_not_full, push, count_q < CW'(DEPTH))
	`GAPD_ASSERT_NOW(a_pop_not_empty, pop, count_q != '0)
	`GAPD_ASSERT_NEXT(a_drop_none, accept && (mode == MODE_NONE) && !pop, $stable(count_q))

endmodule

>>> hdl/gapd_back.sv
`timescale 1ns / 1ps
`include "gate_array_pixel_decode_defines.svh"

module gapd_back import gapd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  queue_head_t head,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [COLOUR_W-1:0] colour_code,
	output logic [PEN_W-1:0]    pen_number,
	output logic        last_pixel
);

	pair_t         pair_q;
	logic          busy_q;
	logic [3:0]    cnt_q;
	logic          out_valid_q;
	logic          advance;
	logic          load;
	logic [7:0]    cur_byte;
	logic [PEN_W-1:0] pen;

	assign advance  = busy_q && (!out_valid_q || m_tready);
	assign load     = !busy_q || (advance && (cnt_q == 4'd15));
	assign pop      = load && head.valid;
	assign cur_byte = cnt_q[3] ? pair_q.second_byte : pair_q.first_byte;
	assign pen      = pen_of(cfg.mode, cur_byte, cnt_q[2:0]);
	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk) begin
		if (load) begin
			pair_q <= head.pair;
		end
		if (advance) begin
			pen_number  <= pen;
			colour_code <= colour_of(pen, cfg.pal_low, cfg.pal_high);
			last_pixel  <= (cnt_q == 4'd15);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			// counter wraps to zero on the sixteenth pixel, cleared while idle
			if (advance) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (load) begin
				cnt_q <= '0;
			end
			if (load) begin
				busy_q <= head.valid;
			end
		end
	end

	`GAPD_ASSERT_NEXT(a_idle_after_last, advance && (cnt_q == 4'd15) && !head.valid, !busy_q)
	`GAPD_ASSERT_NOW(a_load_from_start, pop && busy_q, advance && (cnt_q == 4'd15))
	`GAPD_ASSERT_NEXT(a_last_at_end, advance, last_pixel == ($past(cnt_q) == 4'd15))

endmodule

>>> hdl/gate_array_pixel_decode.sv
`timescale 1ns / 1ps

// gate array pixel decoder: each accepted transaction on the s_ side carries a pair of
// video bytes and yields sixteen pixel transactions on the m_ side, leftmost pixel first,
// each with its decoded pen and that pen's five-bit colour code from a sixteen-pen palette.
// mode 0 gives two pens per byte shown four pixels each, mode 1 four pens per byte shown
// two pixels each, mode 2 one bit per pixel; in mode 3 pairs are taken and dropped with
// no output. m_tlast marks the sixteenth pixel of a pair. the output serializer emits one
// pixel per cycle while m_tready stays high; a pair moves from the queue to the pair
// register and from there to the output register. a small queue sits in front of
// the serializer so the next pairs are taken while the current one is still going out.
// configuration writes (mode, palette low pens 0-7, palette high pens 8-15) are always
// ready and must only be made while no pixels are pending; index 3 is ignored.

module gate_array_pixel_decode import gapd_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [39:0] cfg_data,
	// byte pair input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] first_byte, [15:8] second_byte
	// pixel output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [4:0] colour_code, [8:5] pen_number, [15:9] zero
	output logic        m_tlast    // last_pixel
);

	cfg_t        cfg_q;
	queue_head_t head;
	logic        pop;
	logic [COLOUR_W-1:0] colour_code;
	logic [PEN_W-1:0]    pen_number;

	// config registers, written on every cfg transaction with index 0 to 2
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode     <= MODE_LOW;
			cfg_q.pal_low  <= '0;
			cfg_q.pal_high <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SCREEN_MODE:  cfg_q.mode     <= screen_mode_t'(cfg_data[1:0]);
				REG_PALETTE_LOW:  cfg_q.pal_low  <= cfg_data[PAL_W-1:0];
				REG_PALETTE_HIGH: cfg_q.pal_high <= cfg_data[PAL_W-1:0];
				default:          cfg_q          <= cfg_q;
			endcase
		end
	end

	// front end: takes pairs, drops mode 3 pairs, queues the rest
	gapd_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.mode     (cfg_q.mode),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_pair   (pair_t'(s_tdata)),
		.head     (head),
		.pop      (pop)
	);

	// back end: serializes one pixel per cycle into the output register while m_tready does not hold it
	gapd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.head        (head),
		.pop         (pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.colour_code (colour_code),
		.pen_number  (pen_number),
		.last_pixel  (m_tlast)
	);

	assign m_tdata = {7'b0000000, pen_number, colour_code};

endmodule
